// ===== hdl/rlc_pkg.sv =====
package rlc_pkg;

    localparam int CHUNK_W = 32;
    localparam int KEY_W   = 27;
    localparam int SLOT_W  = 4;

    typedef logic signed [CHUNK_W-1:0] chunk_t;
    typedef logic signed [KEY_W-1:0]   key_t;

    // outcome of one lookup, handed from the tag store to the result register
    typedef struct packed {
        logic hit;
        logic evicted;
        key_t evicted_x;
        key_t evicted_z;
    } lookup_t;

endpackage

// ===== hdl/rlc_store.sv =====
module rlc_store #(
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  rlc_pkg::key_t              req_x,
    input  rlc_pkg::key_t              req_z,
    output rlc_pkg::lookup_t           res,
    output logic [$clog2(ENTRIES)-1:0] res_slot
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] OLDEST = IDX_W'(ENTRIES - 1);

    logic                  slot_valid_reg [ENTRIES];
    logic                  slot_valid_next[ENTRIES];
    rlc_pkg::key_t         slot_key_x_reg [ENTRIES];
    rlc_pkg::key_t         slot_key_z_reg [ENTRIES];
    logic [IDX_W-1:0]      slot_age_reg   [ENTRIES];
    logic [IDX_W-1:0]      slot_age_next  [ENTRIES];

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    oldest;
    logic                  hit;
    logic                  any_free;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic [IDX_W-1:0]      sel_idx;
    logic [IDX_W-1:0]      sel_age;
    logic                  evict;

    always_comb
    begin
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        any_free   = 1'b0;
        // walk downward so the lowest matching index wins
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i]  = slot_valid_reg[i] && (slot_key_x_reg[i] == req_x)
                        && (slot_key_z_reg[i] == req_z);
            oldest[i] = (slot_age_reg[i] == OLDEST);
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
            if (oldest[i])
            begin
                victim_idx = IDX_W'(i);
            end
        end
        hit   = |match;
        evict = !hit && !any_free;
        if (hit)
        begin
            sel_idx = hit_idx;
        end
        else if (any_free)
        begin
            sel_idx = free_idx;
        end
        else
        begin
            sel_idx = victim_idx;
        end
        sel_age = slot_age_reg[sel_idx];

        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_valid_next[i] = slot_valid_reg[i];
            slot_age_next[i]   = slot_age_reg[i];
            if (slot_age_reg[i] < sel_age)
            begin
                slot_age_next[i] = slot_age_reg[i] + 1'b1;
            end
        end
        slot_age_next[sel_idx]   = '0;
        slot_valid_next[sel_idx] = 1'b1;
    end

    assign res.hit       = hit;
    assign res.evicted   = evict;
    assign res.evicted_x = evict ? slot_key_x_reg[victim_idx] : '0;
    assign res.evicted_z = evict ? slot_key_z_reg[victim_idx] : '0;
    assign res_slot      = sel_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
                slot_age_reg[i]   <= IDX_W'(i);
            end
        end
        else if (req_valid)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_valid_reg[i] <= slot_valid_next[i];
                slot_age_reg[i]   <= slot_age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !hit)
        begin
            slot_key_x_reg[sel_idx] <= req_x;
            slot_key_z_reg[sel_idx] <= req_z;
        end
    end

    // a key lives in at most one valid slot
    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("region key cached in more than one slot");

    // ages stay a permutation, so exactly one slot is the oldest
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(oldest))
        else $error("no single least recent slot");

    a_sel_recent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |=> (slot_age_reg[$past(sel_idx)] == '0)
                      && slot_valid_reg[$past(sel_idx)])
        else $error("chosen slot not made most recent and valid");

    a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !hit) |=> (slot_key_x_reg[$past(sel_idx)] == $past(req_x))
                                && (slot_key_z_reg[$past(sel_idx)] == $past(req_z)))
        else $error("missed key not installed");

endmodule

// ===== hdl/region_lru_cache_lookup.sv =====
// channel | valid     | stall     | word
// --------+-----------+-----------+-----------------------------------------------
// input   | in_valid  | in_stall  | chunk_x, chunk_z
// output  | out_valid | out_stall | hit, slot, region_x, region_z,
//         |           |           | evicted, evicted_x, evicted_z
//
// one word per cycle while the output is not stalled; an accepted word passes stage one
// and then the result register; stage one registers the region keys, stage two
// searches the tag store and updates recency as it writes the result register
// rst_n clears every slot to invalid with ages in slot order; no clearing pass
// a stall at the output holds the result register and backs up into in_stall
module region_lru_cache_lookup #(
    parameter int ENTRIES      = 16,
    parameter int REGION_SHIFT = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rlc_pkg::CHUNK_W-1:0]   chunk_x,
    input  logic signed [rlc_pkg::CHUNK_W-1:0]   chunk_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic        [rlc_pkg::SLOT_W-1:0]    slot,
    output logic signed [rlc_pkg::KEY_W-1:0]     region_x,
    output logic signed [rlc_pkg::KEY_W-1:0]     region_z,
    output logic                                 evicted,
    output logic signed [rlc_pkg::KEY_W-1:0]     evicted_x,
    output logic signed [rlc_pkg::KEY_W-1:0]     evicted_z
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    rlc_pkg::key_t        s1_rx_reg;
    rlc_pkg::key_t        s1_rz_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic [rlc_pkg::SLOT_W-1:0] slot_reg;
    rlc_pkg::key_t        region_x_reg;
    rlc_pkg::key_t        region_z_reg;
    logic                 evicted_reg;
    rlc_pkg::key_t        evicted_x_reg;
    rlc_pkg::key_t        evicted_z_reg;

    logic                 out_free;
    logic                 s1_adv;
    logic                 accept;
    rlc_pkg::chunk_t      shift_x;
    rlc_pkg::chunk_t      shift_z;
    rlc_pkg::lookup_t     res;
    logic [IDX_W-1:0]     res_slot;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // floor division by a power of two is an arithmetic shift
    assign shift_x = chunk_x >>> REGION_SHIFT;
    assign shift_z = chunk_z >>> REGION_SHIFT;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    rlc_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s1_adv),
        .req_x     (s1_rx_reg),
        .req_z     (s1_rz_reg),
        .res       (res),
        .res_slot  (res_slot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rx_reg <= shift_x[rlc_pkg::KEY_W-1:0];
            s1_rz_reg <= shift_z[rlc_pkg::KEY_W-1:0];
        end
        if (s1_adv)
        begin
            hit_reg       <= res.hit;
            slot_reg      <= rlc_pkg::SLOT_W'(res_slot);
            region_x_reg  <= s1_rx_reg;
            region_z_reg  <= s1_rz_reg;
            evicted_reg   <= res.evicted;
            evicted_x_reg <= res.evicted_x;
            evicted_z_reg <= res.evicted_z;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign slot      = slot_reg;
    assign region_x  = region_x_reg;
    assign region_z  = region_z_reg;
    assign evicted   = evicted_reg;
    assign evicted_x = evicted_x_reg;
    assign evicted_z = evicted_z_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int ENTRIES      = 16;
    localparam int REGION_SHIFT = 5;
    localparam int LIMIT        = 400000;
    localparam int RANDOM_WORDS = 1750;

    typedef struct {
        logic                       hit;
        logic [rlc_pkg::SLOT_W-1:0] slot;
        rlc_pkg::key_t              region_x;
        rlc_pkg::key_t              region_z;
        logic                       evicted;
        rlc_pkg::key_t              evicted_x;
        rlc_pkg::key_t              evicted_z;
    } lookup_result_t;

    class region_scoreboard;
        lookup_result_t pending_q[$];
        logic           tag_valid[ENTRIES];
        rlc_pkg::key_t  tag_x[ENTRIES];
        rlc_pkg::key_t  tag_z[ENTRIES];
        logic [7:0]     recency[ENTRIES];
        int             fails;
        int             checked;
        int             n_hits;
        int             n_fills;
        int             n_evicts;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_valid[i] = 1'b0;
                tag_x[i]     = '0;
                tag_z[i]     = '0;
                recency[i]   = 8'(i);
            end
            fails    = 0;
            checked  = 0;
            n_hits   = 0;
            n_fills  = 0;
            n_evicts = 0;
        endfunction

        function rlc_pkg::key_t region_of(rlc_pkg::chunk_t c);
            rlc_pkg::chunk_t q;
            q = c >>> REGION_SHIFT;
            return q[rlc_pkg::KEY_W-1:0];
        endfunction

        // predict the lookup for an accepted word and queue it
        function void note_input(rlc_pkg::chunk_t cx, rlc_pkg::chunk_t cz);
            lookup_result_t r;
            int             s;
            bit             found;
            logic [7:0]     a;
            r.region_x  = region_of(cx);
            r.region_z  = region_of(cz);
            r.hit       = 1'b0;
            r.evicted   = 1'b0;
            r.evicted_x = '0;
            r.evicted_z = '0;
            s = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (!r.hit && tag_valid[i] && tag_x[i] == r.region_x && tag_z[i] == r.region_z)
                begin
                    r.hit = 1'b1;
                    s = i;
                end
            if (!r.hit)
            begin
                found = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (!found && !tag_valid[i])
                    begin
                        found = 1;
                        s = i;
                    end
                if (!found)
                begin
                    // oldest slot, lowest index on a tie
                    s = 0;
                    for (int i = 1; i < ENTRIES; i++)
                        if (recency[i] > recency[s])
                            s = i;
                    r.evicted   = 1'b1;
                    r.evicted_x = tag_x[s];
                    r.evicted_z = tag_z[s];
                end
                tag_valid[s] = 1'b1;
                tag_x[s]     = r.region_x;
                tag_z[s]     = r.region_z;
            end
            a = recency[s];
            for (int i = 0; i < ENTRIES; i++)
                if (recency[i] < a)
                    recency[i] = recency[i] + 8'd1;
            recency[s] = 8'd0;
            r.slot = s[rlc_pkg::SLOT_W-1:0];
            if (r.hit)
                n_hits++;
            else if (r.evicted)
                n_evicts++;
            else
                n_fills++;
            pending_q = {pending_q, r};
        endfunction

        function void check_result(logic hit, logic [rlc_pkg::SLOT_W-1:0] slot,
                                   rlc_pkg::key_t rx, rlc_pkg::key_t rz,
                                   logic ev, rlc_pkg::key_t ex, rlc_pkg::key_t ez);
            lookup_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("result word with nothing expected");
                fails++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (hit !== e.hit)
            begin
                $error("hit: expected %0d, got %0d", e.hit, hit);
                fails++;
            end
            if (slot !== e.slot)
            begin
                $error("slot: expected %0d, got %0d", e.slot, slot);
                fails++;
            end
            if (rx !== e.region_x)
            begin
                $error("region_x: expected %0d, got %0d", e.region_x, rx);
                fails++;
            end
            if (rz !== e.region_z)
            begin
                $error("region_z: expected %0d, got %0d", e.region_z, rz);
                fails++;
            end
            if (ev !== e.evicted)
            begin
                $error("evicted: expected %0d, got %0d", e.evicted, ev);
                fails++;
            end
            if (ex !== e.evicted_x)
            begin
                $error("evicted_x: expected %0d, got %0d", e.evicted_x, ex);
                fails++;
            end
            if (ez !== e.evicted_z)
            begin
                $error("evicted_z: expected %0d, got %0d", e.evicted_z, ez);
                fails++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    rlc_pkg::chunk_t            chunk_x;
    rlc_pkg::chunk_t            chunk_z;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       hit;
    logic [rlc_pkg::SLOT_W-1:0] slot;
    rlc_pkg::key_t              region_x;
    rlc_pkg::key_t              region_z;
    logic                       evicted;
    rlc_pkg::key_t              evicted_x;
    rlc_pkg::key_t              evicted_z;

    region_scoreboard sb = new();

    int            cycle_count = 0;
    int            stall_mode  = 0;
    int            mode_left   = 50;
    int            words_sent;
    rlc_pkg::key_t key_pool[32];
    int            pool_n;

    region_lru_cache_lookup #(
        .ENTRIES      (ENTRIES),
        .REGION_SHIFT (REGION_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .chunk_x   (chunk_x),
        .chunk_z   (chunk_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .slot      (slot),
        .region_x  (region_x),
        .region_z  (region_z),
        .evicted   (evicted),
        .evicted_x (evicted_x),
        .evicted_z (evicted_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: take results and stall on its own changing pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(hit, slot, region_x, region_z, evicted, evicted_x, evicted_z);
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= cycle_count[2];
        endcase
    end

    task automatic send_word(input rlc_pkg::chunk_t x, input rlc_pkg::chunk_t z);
        in_valid <= 1'b1;
        chunk_x  <= x;
        chunk_z  <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(x, z);
        words_sent++;
    endtask

    task automatic idle_gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic rlc_pkg::key_t make_key();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 1))
            return r[rlc_pkg::KEY_W-1:0];
        return rlc_pkg::key_t'(int'($urandom_range(0, 15)) - 8);
    endfunction

    function automatic void refill_pool();
        pool_n = $urandom_range(4, 28);
        for (int i = 0; i < pool_n; i++)
            key_pool[i] = make_key();
    endfunction

    // a chunk inside a pooled region, or a wild coordinate now and then
    function automatic rlc_pkg::chunk_t pick_chunk();
        logic [4:0] low;
        int         pick;
        low  = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return rlc_pkg::chunk_t'($urandom);
        if (pick < 15)
            return ($urandom_range(0, 1)) ? rlc_pkg::chunk_t'(32'h7FFF_FFFF)
                                          : rlc_pkg::chunk_t'(32'h8000_0000);
        return {key_pool[$urandom_range(0, pool_n - 1)], low};
    endfunction

    task automatic run_directed();
        // a zero key must still miss while every slot is invalid
        send_word(0, 0);
        send_word(31, 31);
        send_word(32, -1);
        send_word(-32, -33);
        send_word(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(-1, -1);
        // fill the remaining free slots
        for (int k = 2; k < 12; k++)
            send_word(k * 32, k * 64);
        // hit in the middle of the recency order
        send_word(33, -5);
        // full store, oldest entries get replaced
        send_word(1000000, -1000000);
        send_word(-2000000, 2000000);
        send_word(5, 7);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        chunk_x     = '0;
        chunk_z     = '0;
        words_sent  = 0;
        refill_pool();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        while (words_sent < RANDOM_WORDS + 21)
        begin
            int burst;
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 5) == 0)
                refill_pool();
            for (int i = 0; i < burst; i++)
                send_word(pick_chunk(), pick_chunk());
            if ($urandom_range(0, 9) < 3)
                continue;
            idle_gap($urandom_range(1, 6));
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d lookups checked over %0d cycles", sb.checked, cycle_count);
        $display("%0d hits, %0d fills of free slots, %0d evictions", sb.n_hits, sb.n_fills,
                 sb.n_evicts);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
